FILE: rtl/aes128_pkg.sv
// Package for the AES-128 block cipher core: types, constants, S-box tables
// and GF(2^8) helper functions. No dependencies.
package aes128_pkg;

    localparam int NumRounds  = 10;
    localparam int KeyWords   = 2 * (NumRounds + 1);
    localparam int KeyAddrW   = $clog2(KeyWords);
    localparam int CfgIdxW    = 1;

    localparam logic [CfgIdxW-1:0] RegKeyHigh = 1'b0;
    localparam logic [CfgIdxW-1:0] RegKeyLow  = 1'b1;

    typedef logic [7:0]   t_byte;
    typedef logic [127:0] t_block;
    typedef logic [KeyAddrW-1:0] t_key_addr;

    typedef struct packed {
        logic         mode;
        logic [63:0]  block_high;
        logic [63:0]  block_low;
    } t_in_item;

    typedef struct packed {
        logic [63:0]  result_high;
        logic [63:0]  result_low;
    } t_out_item;

    function automatic t_byte sbox(input t_byte a);
        t_byte t [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[a];
    endfunction

    function automatic t_byte inv_sbox(input t_byte a);
        t_byte t [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        return t[a];
    endfunction

    function automatic t_byte xtime(input t_byte a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
    endfunction

    // byte i of the block sits at bits 127-8i .. 120-8i
    function automatic t_byte get_byte(input t_block s, input int i);
        return s[127 - 8*i -: 8];
    endfunction

    function automatic t_block sub_shift(input t_block s, input logic inv);
        t_block t;
        t = '0;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                if (inv) begin
                    t[127 - 8*(r + 4*((c + r) % 4)) -: 8] = inv_sbox(get_byte(s, r + 4*c));
                end else begin
                    t[127 - 8*(r + 4*c) -: 8] = sbox(get_byte(s, r + 4*((c + r) % 4)));
                end
            end
        end
        return t;
    endfunction

    function automatic t_block mix_cols(input t_block s, input logic inv);
        t_block t;
        t_byte a0, a1, a2, a3, x0, x1, x2, x3, u, v;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            a0 = get_byte(s, 4*c);
            a1 = get_byte(s, 4*c + 1);
            a2 = get_byte(s, 4*c + 2);
            a3 = get_byte(s, 4*c + 3);
            if (inv) begin
                // InvMix = Mix after a pre-step with 4*(a0^a2), 4*(a1^a3)
                u  = xtime(xtime(a0 ^ a2));
                v  = xtime(xtime(a1 ^ a3));
                a0 = a0 ^ u;
                a1 = a1 ^ v;
                a2 = a2 ^ u;
                a3 = a3 ^ v;
            end
            x0 = xtime(a0);
            x1 = xtime(a1);
            x2 = xtime(a2);
            x3 = xtime(a3);
            t[127 - 32*c -: 8]      = x0 ^ x1 ^ a1 ^ a2 ^ a3;
            t[127 - 32*c - 8 -: 8]  = a0 ^ x1 ^ x2 ^ a2 ^ a3;
            t[127 - 32*c - 16 -: 8] = a0 ^ a1 ^ x2 ^ x3 ^ a3;
            t[127 - 32*c - 24 -: 8] = x0 ^ a0 ^ a1 ^ a2 ^ x3;
        end
        return t;
    endfunction

endpackage

FILE: rtl/aes128_if.sv
// Valid/ready channel interface carrying a generic payload.
// Depends on aes128_pkg for payload types.
interface aes128_if #(parameter type T = aes128_pkg::t_in_item) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/aes128_block_cipher_core.sv
// AES-128 ECB encrypt/decrypt core, one item at a time. The key sits in two 64-bit
// registers, to be written by the user only while no item is in flight; the block
// itself does not enforce it. The first item accepted after a key write waits while
// the eleven round keys are expanded into the 22-entry round key RAM, each round key
// written as two 64-bit halves. The item is then worked with one 64-bit RAM read a
// cycle and, for each round key read, the initial key addition or one round of the
// single shared round unit. The result is then loaded into the output register and
// the core returns to idle, so no new item is accepted before the last one's result
// has reached that register. If the output register still holds an unread result,
// the finished item waits for it and the input stays closed; the input opens as soon
// as the result has moved into the register.
// Depends on aes128_pkg and aes128_if.
module aes128_block_cipher_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [aes128_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  logic [63:0]                      i_cfg_data,
    aes128_if.sink                           i_in,
    aes128_if.source                         o_out
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_KEXP = 4'b0010,
        ST_RUN  = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [63:0] r_key_high, r_key_low;
    logic        r_key_pending;

    // round key RAM: entry 2k holds bytes 0..7 of round key k, 2k+1 bytes 8..15
    logic [63:0] r_rk_mem [aes128_pkg::KeyWords];
    logic [63:0] r_rk_q;
    logic [63:0] r_rk_rd;
    aes128_pkg::t_key_addr r_rd_addr;

    // key expansion: the current round key as four words
    logic [31:0] r_w [4];
    aes128_pkg::t_key_addr r_kcnt;
    logic [7:0]  r_rcon;

    logic         r_mode;
    aes128_pkg::t_block r_st;
    logic [3:0]   r_round;     // round whose key arrives this cycle
    logic         r_rd_valid;

    logic         r_out_valid;
    aes128_pkg::t_out_item r_out;

    logic         in_fire, out_fire, rk_apply, first_key, last_key;
    logic [31:0]  kw_t, rot;
    logic [31:0]  kw_n [4];
    aes128_pkg::t_block rk, ss, ad, st_next;

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_fire = o_out.valid && o_out.ready;
    assign i_in.ready  = (r_state == ST_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // next round key from the current one
    always_comb begin
        rot  = {r_w[3][23:0], r_w[3][31:24]};
        kw_t = {aes128_pkg::sbox(rot[31:24]) ^ r_rcon, aes128_pkg::sbox(rot[23:16]),
                aes128_pkg::sbox(rot[15:8]), aes128_pkg::sbox(rot[7:0])};
        kw_n[0] = r_w[0] ^ kw_t;
        kw_n[1] = r_w[1] ^ kw_n[0];
        kw_n[2] = r_w[2] ^ kw_n[1];
        kw_n[3] = r_w[3] ^ kw_n[2];
    end

    assign rk = {r_rk_rd, r_rk_q};

    // key pair complete when the odd half has just been read
    assign rk_apply  = r_rd_valid && !r_rd_addr[0];
    assign first_key = r_mode ? (r_round == 4'(aes128_pkg::NumRounds)) : (r_round == 4'd0);
    assign last_key  = r_mode ? (r_round == 4'd0) : (r_round == 4'(aes128_pkg::NumRounds));

    // one key per step: initial addition, then encrypt rounds 1..10, decrypt 9..0
    always_comb begin
        ss = aes128_pkg::sub_shift(r_st, r_mode);
        ad = ss ^ rk;
        if (first_key) begin
            st_next = r_st ^ rk;
        end else if (!r_mode) begin
            st_next = (last_key ? ss : aes128_pkg::mix_cols(ss, 1'b0)) ^ rk;
        end else begin
            st_next = last_key ? ad : aes128_pkg::mix_cols(ad, 1'b1);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (in_fire) n_state = r_key_pending ? ST_KEXP : ST_RUN;
            ST_KEXP: begin
                if (r_kcnt == aes128_pkg::t_key_addr'(aes128_pkg::KeyWords - 1)) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN:  if (rk_apply && last_key) n_state = ST_DONE;
            ST_DONE: if (!r_out_valid || out_fire) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // RAM: synchronous write, registered read
    always_ff @(posedge i_clk) begin
        if (r_state == ST_KEXP) begin
            r_rk_mem[r_kcnt] <= r_kcnt[0] ? {r_w[2], r_w[3]} : {r_w[0], r_w[1]};
        end
        r_rk_q  <= r_rk_mem[r_rd_addr];
        r_rk_rd <= r_rk_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_key_high    <= '0;
            r_key_low     <= '0;
            r_key_pending <= 1'b0;
            r_out_valid   <= 1'b0;
            r_rd_valid    <= 1'b0;
            r_kcnt        <= '0;
            r_rd_addr     <= '0;
            r_round       <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    aes128_pkg::RegKeyHigh: r_key_high <= i_cfg_data;
                    aes128_pkg::RegKeyLow:  r_key_low  <= i_cfg_data;
                    default: ;
                endcase
                r_key_pending <= 1'b1;
            end else if (in_fire) begin
                r_key_pending <= 1'b0;
            end

            if (r_state == ST_DONE && (!r_out_valid || out_fire)) begin
                r_out_valid <= 1'b1;
            end else if (out_fire) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        r_mode     <= i_in.data.mode;
                        r_st       <= {i_in.data.block_high, i_in.data.block_low};
                        r_kcnt     <= '0;
                        r_rcon     <= 8'h01;
                        r_w[0]     <= r_key_high[63:32];
                        r_w[1]     <= r_key_high[31:0];
                        r_w[2]     <= r_key_low[63:32];
                        r_w[3]     <= r_key_low[31:0];
                        r_rd_valid <= 1'b0;
                        r_round    <= i_in.data.mode ? 4'(aes128_pkg::NumRounds) : 4'd0;
                        r_rd_addr  <= i_in.data.mode
                                    ? aes128_pkg::t_key_addr'(2 * aes128_pkg::NumRounds) : '0;
                    end
                end
                ST_KEXP: begin
                    // even count writes the first half, odd the second, then step
                    r_kcnt <= r_kcnt + 1'b1;
                    if (r_kcnt[0]) begin
                        r_w    <= kw_n;
                        r_rcon <= aes128_pkg::xtime(r_rcon);
                    end
                    r_rd_addr <= r_mode
                               ? aes128_pkg::t_key_addr'(2 * aes128_pkg::NumRounds) : '0;
                end
                ST_RUN: begin
                    if (r_rd_addr[0]) begin
                        r_rd_addr <= r_mode ? r_rd_addr - 5'd3 : r_rd_addr + 5'd1;
                    end else begin
                        r_rd_addr <= r_rd_addr ^ 5'd1;
                    end
                    r_rd_valid <= 1'b1;
                    if (rk_apply) begin
                        r_st    <= st_next;
                        r_round <= r_mode ? r_round - 4'd1 : r_round + 4'd1;
                    end
                end
                ST_DONE: begin
                    if (!r_out_valid || out_fire) begin
                        r_out <= {r_st[127:64], r_st[63:0]};
                    end
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state));
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid && $stable(o_out.data));
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !i_in.ready);
    a_kcnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_KEXP |-> r_kcnt < aes128_pkg::t_key_addr'(aes128_pkg::KeyWords));
`endif

endmodule

FILE: sim/tb.sv
// Testbench for the AES-128 ECB cipher core: drives blocks under several keys,
// predicts each result with its own cipher code and checks it field by field.
// Depends on aes128_pkg, aes128_if and the core.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MaxCycles = 400_000;
    localparam int DrainCycles = 80;
    localparam int StallCycles = 300;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [aes128_pkg::CfgIdxW-1:0] i_cfg_idx = aes128_pkg::RegKeyHigh;
    logic [63:0] i_cfg_data = '0;

    aes128_if #(.T(aes128_pkg::t_in_item)) in_ch ();
    aes128_if #(.T(aes128_pkg::t_out_item)) out_ch ();

    aes128_block_cipher_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic [63:0] key_hi_q = '0, key_lo_q = '0;
    logic        rekey_due = 1'b0;
    logic [31:0] rk_words [44];

    aes128_pkg::t_in_item  pending_blocks[$];
    aes128_pkg::t_out_item expected_blocks[$];
    int        mismatches = 0;
    int        blocks_checked = 0;
    int        send_idle_pct = 27, recv_idle_pct = 47;
    int        hold_recv = 0;
    bit        stall_go = 1'b0;
    bit        stall_done = 1'b0;
    bit        done_flag = 1'b0;

    logic [7:0] fwd_tab [256];
    logic [7:0] rev_tab [256];

    function automatic logic [7:0] gmul2(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = '0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p ^= a;
            a = gmul2(a);
        end
        return p;
    endfunction

    // byte i is at bits 127-8i
    function automatic logic [7:0] byte_at(input logic [127:0] s, input int i);
        return s[127-8*i -: 8];
    endfunction

    task automatic expand_schedule();
        logic [31:0] t;
        logic [7:0] rc;
        rc = 8'h01;
        rk_words[0] = key_hi_q[63:32]; rk_words[1] = key_hi_q[31:0];
        rk_words[2] = key_lo_q[63:32]; rk_words[3] = key_lo_q[31:0];
        for (int i = 4; i < 44; i++) begin
            t = rk_words[i-1];
            if (i % 4 == 0) begin
                t = {t[23:0], t[31:24]};
                t = {fwd_tab[t[31:24]], fwd_tab[t[23:16]], fwd_tab[t[15:8]], fwd_tab[t[7:0]]};
                t ^= {rc, 24'h0};
                rc = gmul2(rc);
            end
            rk_words[i] = rk_words[i-4] ^ t;
        end
    endtask

    function automatic logic [127:0] round_key(input int k);
        return {rk_words[4*k], rk_words[4*k+1], rk_words[4*k+2], rk_words[4*k+3]};
    endfunction

    function automatic logic [127:0] sub_rows(input logic [127:0] s, input bit inv);
        logic [127:0] t;
        int moved;
        t = '0;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++) begin
                moved = r + 4*((c + r) % 4);
                if (inv) t[127-8*moved -: 8] = rev_tab[byte_at(s, r + 4*c)];
                else t[127-8*(r+4*c) -: 8] = fwd_tab[byte_at(s, moved)];
            end
        return t;
    endfunction

    function automatic logic [127:0] mix(input logic [127:0] s, input bit inv);
        logic [7:0] m [4];
        logic [7:0] acc;
        logic [127:0] t;
        if (inv) m = '{8'h0E, 8'h0B, 8'h0D, 8'h09};
        else m = '{8'h02, 8'h03, 8'h01, 8'h01};
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) begin
                acc = '0;
                for (int k = 0; k < 4; k++)
                    acc ^= gmul(m[(k - r + 4) % 4], byte_at(s, k + 4*c));
                t[127-8*(r+4*c) -: 8] = acc;
            end
        return t;
    endfunction

    task automatic predict_cipher(input aes128_pkg::t_in_item it);
        logic [127:0] s;
        aes128_pkg::t_out_item o;
        if (rekey_due) begin
            expand_schedule();
            rekey_due = 1'b0;
        end
        s = {it.block_high, it.block_low};
        if (!it.mode) begin
            s ^= round_key(0);
            for (int rd = 1; rd <= aes128_pkg::NumRounds; rd++) begin
                s = sub_rows(s, 1'b0);
                if (rd != aes128_pkg::NumRounds) s = mix(s, 1'b0);
                s ^= round_key(rd);
            end
        end else begin
            s ^= round_key(aes128_pkg::NumRounds);
            for (int rd = aes128_pkg::NumRounds - 1; rd >= 0; rd--) begin
                s = sub_rows(s, 1'b1);
                s ^= round_key(rd);
                if (rd != 0) s = mix(s, 1'b1);
            end
        end
        o.result_high = s[127:64];
        o.result_low = s[63:0];
        expected_blocks.push_back(o);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %h want %h", what, got, want);
        mismatches++;
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.data <= '0;
        end else begin
            if (in_ch.valid && in_ch.ready) predict_cipher(in_ch.data);
            if (!in_ch.valid || in_ch.ready) begin
                if (pending_blocks.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_ch.valid <= 1'b1;
                    in_ch.data <= pending_blocks.pop_front();
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver stall, counted in cycles
    always @(posedge i_clk) begin
        if (stall_go && !stall_done) begin
            hold_recv <= StallCycles;
            stall_done <= 1'b1;
        end else if (hold_recv > 0) begin
            hold_recv <= hold_recv - 1;
        end
    end

    // monitor and receiver
    always @(posedge i_clk) begin
        aes128_pkg::t_out_item want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_blocks.size() == 0) begin
                    report_mismatch("unexpected block", out_ch.data.result_high, '0);
                end else begin
                    want = expected_blocks.pop_front();
                    if (out_ch.data.result_high !== want.result_high)
                        report_mismatch("result_high", out_ch.data.result_high,
                                        want.result_high);
                    if (out_ch.data.result_low !== want.result_low)
                        report_mismatch("result_low", out_ch.data.result_low,
                                        want.result_low);
                    blocks_checked++;
                end
            end
            if (hold_recv > 0) begin
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic write_key(input logic [aes128_pkg::CfgIdxW-1:0] idx, input logic [63:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == aes128_pkg::RegKeyHigh) key_hi_q = v;
        else key_lo_q = v;
        rekey_due = 1'b1;
    endtask

    task automatic drain();
        while (pending_blocks.size() > 0 || in_ch.valid || expected_blocks.size() > 0)
            @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic push_block(input bit md, input logic [63:0] h, input logic [63:0] l);
        aes128_pkg::t_in_item it;
        it.mode = md; it.block_high = h; it.block_low = l;
        pending_blocks.push_back(it);
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    initial begin
        for (int i = 0; i < 256; i++) begin
            fwd_tab[i] = aes128_pkg::sbox(i[7:0]);
            rev_tab[fwd_tab[i]] = i[7:0];
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // standard test key, then known vector both ways, then all-zero and all-one blocks
        write_key(aes128_pkg::RegKeyHigh, 64'h0001020304050607);
        write_key(aes128_pkg::RegKeyLow, 64'h08090a0b0c0d0e0f);
        push_block(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff);
        push_block(1'b1, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
        push_block(1'b0, '0, '0);
        push_block(1'b0, '1, '1);
        push_block(1'b1, '0, '0);
        push_block(1'b1, '1, '1);
        drain();
        // extreme keys, and a single-register rewrite
        write_key(aes128_pkg::RegKeyHigh, '0);
        write_key(aes128_pkg::RegKeyLow, '0);
        push_block(1'b0, '0, '0);
        push_block(1'b1, '1, '0);
        drain();
        write_key(aes128_pkg::RegKeyHigh, '1);
        write_key(aes128_pkg::RegKeyLow, '1);
        push_block(1'b0, '0, '1);
        push_block(1'b1, 64'h8000000000000001, 64'h0123456789abcdef);
        drain();
        write_key(aes128_pkg::RegKeyLow, 64'h5555aaaa5555aaaa);
        push_block(1'b0, rnd64(), rnd64());
        push_block(1'b1, rnd64(), rnd64());
        drain();
        // random phases with different idling mixes and fresh keys
        for (int ph = 0; ph < 4; ph++) begin
            if (ph == 1) begin send_idle_pct = 47; recv_idle_pct = 27; end
            if (ph >= 2) begin send_idle_pct = 0; recv_idle_pct = 0; end
            write_key(aes128_pkg::RegKeyHigh, rnd64());
            write_key(aes128_pkg::RegKeyLow, rnd64());
            for (int n = 0; n < 100; n++)
                push_block(1'($urandom_range(1)), rnd64(), rnd64());
            if (ph == 3) begin
                // long receiver stall while items keep coming
                while (blocks_checked == 0 || pending_blocks.size() > 95) @(posedge i_clk);
                stall_go = 1'b1;
            end
            drain();
        end
        $display("Covered %0d blocks: known vectors, extreme and random keys, both modes,",
                 blocks_checked);
        $display("under sender and receiver idling and a long output stall.");
        if (mismatches == 0) $display("Verification passed");
        else $display("Verification failed");
        done_flag = 1'b1;
        $finish;
    end

    initial begin
        #(MaxCycles * 10);
        if (!done_flag) begin
            $display("TIMEOUT");
            $display("Verification failed");
            $finish;
        end
    end
endmodule

FILE: files.f
rtl/aes128_pkg.sv
rtl/aes128_if.sv
rtl/aes128_block_cipher_core.sv
sim/tb.sv
